// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising edge while reset is low
`define AAD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked at every rising edge, reset included
`define AAD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/aad_pkg.sv =====
// types, constants and helpers of the area average downscaler
`timescale 1ns / 1ps

package aad_pkg;

  localparam int NCH        = 3;
  localparam int CH_BITS    = 8;
  localparam int NORM_SHIFT = 16;
  localparam int STEP_W     = 13;
  localparam int RECIP_W    = 9;
  localparam int WIDTH_W    = 12;
  localparam int ROW_W      = 21;  // horizontal run sum per channel
  localparam int CVAL_W     = 14;  // normalized column value
  localparam int SUM_W      = 27;  // vertical sum per channel
  localparam int CFG_W      = 13;
  localparam int IDX_W      = 3;
  localparam logic [STEP_W-1:0] UNIT = 13'd256;

  typedef enum logic [IDX_W-1:0] {
    REG_COLOR_MODE = 3'd0,
    REG_SRC_WIDTH  = 3'd1,
    REG_COL_STEP   = 3'd2,
    REG_COL_RECIP  = 3'd3,
    REG_ROW_STEP   = 3'd4,
    REG_ROW_RECIP  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic                color_mode;
    logic [WIDTH_W-1:0]  src_width;
    logic [STEP_W-1:0]   col_step;
    logic [RECIP_W-1:0]  col_recip;
    logic [STEP_W-1:0]   row_step;
    logic [RECIP_W-1:0]  row_recip;
  } cfg_t;

  // one column memory entry: row weight left and three vertical sums
  typedef struct packed {
    logic [STEP_W-1:0]           weight;
    logic [NCH-1:0][SUM_W-1:0]   sum;
  } entry_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_ROWP = 7'b0000010,
    ST_HMUL = 7'b0000100,
    ST_CVAL = 7'b0001000,
    ST_COL  = 7'b0010000,
    ST_VMUL = 7'b0100000,
    ST_EMIT = 7'b1000000
  } state_t;

  // steps below one source pixel count as one
  function automatic logic [STEP_W-1:0] eff_step(input logic [STEP_W-1:0] s);
    return (s < UNIT) ? UNIT : s;
  endfunction

endpackage

// ===== hw/rtl/aad_ram.sv =====
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module aad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/aad_cfg.sv =====
// configuration registers of the area average downscaler
`timescale 1ns / 1ps

module aad_cfg import aad_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.color_mode <= 1'b0;
      cfg.src_width  <= 12'd2048;
      cfg.col_step   <= 13'd512;
      cfg.col_recip  <= 9'd128;
      cfg.row_step   <= 13'd512;
      cfg.row_recip  <= 9'd128;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLOR_MODE: cfg.color_mode <= cfg_data[0];
        REG_SRC_WIDTH:  cfg.src_width  <= cfg_data[WIDTH_W-1:0];
        REG_COL_STEP:   cfg.col_step   <= cfg_data[STEP_W-1:0];
        REG_COL_RECIP:  cfg.col_recip  <= cfg_data[RECIP_W-1:0];
        REG_ROW_STEP:   cfg.row_step   <= cfg_data[STEP_W-1:0];
        REG_ROW_RECIP:  cfg.row_recip  <= cfg_data[RECIP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/area_average_image_downscaler.sv =====
// top level: area averaging downscaler with a per-column accumulator memory
// path: a pixel that finishes an output pixel passes the read, horizontal multiply,
//   column value, column, vertical multiply and emit steps, waiting in emit while the previous output waits
// pacing: a new pixel is taken only in the idle state, once the single read-modify-write
//   sequence on the column memory (one entry read and written per pixel) has ended
// reset: synchronous; no clearing pass, a fill count marks the entries written
//   in the current frame and any other entry reads as empty
`timescale 1ns / 1ps

module area_average_image_downscaler import aad_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic             clk,
  input  logic             rst,
  // source pixels
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [23:0]      s_tdata,   // pixel_in [23:0]
  input  logic [0:0]       s_tuser,   // frame_start [0]
  // downscaled pixels
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [23:0]      m_tdata,   // pixel_out [23:0]
  // configuration writes
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  `include "assert_macros.svh"

  localparam int PW = $clog2(MAX_WIDTH);
  localparam int EW = (PW + 1 > WIDTH_W) ? PW + 1 : WIDTH_W;

  cfg_t cfg;

  aad_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer and position state
  state_t              state, state_next;
  logic [PW-1:0]       pos;        // source column of the next pixel
  logic [PW-1:0]       idx;        // source column of the pixel in flight
  logic [PW:0]         fill;       // entries below this were written this frame
  logic [STEP_W-1:0]   frame_rw;   // row weight of an untouched entry
  logic [STEP_W-1:0]   cw;         // column weight left in the row
  logic [NCH-1:0][ROW_W-1:0] row_run;

  // per pixel working registers
  logic [NCH-1:0][CH_BITS-1:0]       pix;
  entry_t                            entry_q;
  logic [NCH-1:0][ROW_W-1:0]         prod1;
  logic [NCH-1:0][30:0]              prod2;
  logic [NCH-1:0][CVAL_W-1:0]        cval;
  logic [NCH-1:0][SUM_W-1:0]         prod3;
  logic [NCH-1:0][36:0]              prod4;

  // column memory
  logic                   ram_we;
  entry_t                 ram_wdata;
  logic [$bits(entry_t)-1:0] ram_rdata;
  logic [PW-1:0]          ram_raddr;
  entry_t                 entry_eff;

  logic accept, out_free, fin, stale;
  logic [EW-1:0] effw, src_ext, pos_inc;
  logic [STEP_W-1:0] eff_col, eff_row;
  logic [8:0] left, rleft;
  logic [1:0] nch_hi;  // upper channels active in color mode

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = (state == ST_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign ram_raddr = s_tuser[0] ? '0 : pos;
  assign eff_col   = eff_step(cfg.col_step);
  assign eff_row   = eff_step(cfg.row_step);
  assign nch_hi    = {2{cfg.color_mode}};

  aad_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // effective row width, zero acts as one, clipped to the memory depth
  assign src_ext = EW'(cfg.src_width);
  always_comb begin
    if (src_ext == '0) begin
      effw = EW'(1);
    end else if (src_ext > EW'(MAX_WIDTH)) begin
      effw = EW'(MAX_WIDTH);
    end else begin
      effw = src_ext;
    end
  end

  assign pos_inc = EW'(idx) + EW'(1);
  assign stale   = !(EW'(idx) < EW'(fill));
  assign left    = 9'(UNIT - cw);
  assign rleft   = 9'(UNIT - entry_q.weight);

  always_comb begin
    entry_eff = entry_t'(ram_rdata);
    if (stale) begin
      entry_eff.weight = frame_rw;
      entry_eff.sum    = '0;
    end
  end

  // memory write back and next state
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_wdata  = entry_q;
    fin        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_ROWP;
      end
      ST_ROWP: begin
        if (cw > UNIT) begin
          // pixel stays inside the column, entry only marked as written
          ram_we     = 1'b1;
          ram_wdata  = entry_eff;
          fin        = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_HMUL;
        end
      end
      ST_HMUL: state_next = ST_CVAL;
      ST_CVAL: state_next = ST_COL;
      ST_COL: begin
        if (entry_q.weight > UNIT) begin
          ram_we = 1'b1;
          ram_wdata.weight = entry_q.weight - UNIT;
          for (int c = 0; c < NCH; c++) begin
            if (c == 0 || nch_hi[0]) begin
              ram_wdata.sum[c] = entry_q.sum[c] + SUM_W'({cval[c], 8'b0});
            end
          end
          fin        = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_VMUL;
        end
      end
      ST_VMUL: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          ram_we = 1'b1;
          ram_wdata.weight = eff_row - STEP_W'(rleft);
          for (int c = 0; c < NCH; c++) begin
            if (c == 0 || nch_hi[0]) begin
              ram_wdata.sum[c] = SUM_W'(SUM_W'(rleft) * SUM_W'(cval[c]));
            end
          end
          fin        = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pos      <= '0;
      fill     <= '0;
      frame_rw <= 13'd512;
      cw       <= 13'd512;
      row_run  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;

      // output register loads out of the emit step, else empties on a transfer
      if (state == ST_EMIT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      // frame start restarts position, fill count and row
      if (accept && s_tuser[0]) begin
        pos      <= '0;
        fill     <= '0;
        frame_rw <= eff_row;
        cw       <= eff_col;
        row_run  <= '0;
      end

      if (state == ST_ROWP && cw > UNIT && pos_inc < effw) begin
        cw <= cw - UNIT;
        for (int c = 0; c < NCH; c++) begin
          if (c == 0 || nch_hi[0]) begin
            row_run[c] <= row_run[c] + ROW_W'({pix[c], 8'b0});
          end
        end
      end

      // column closes: rest of the pixel opens the next column
      if (state == ST_HMUL) begin
        cw <= eff_col - STEP_W'(left);
        for (int c = 0; c < NCH; c++) begin
          if (c == 0 || nch_hi[0]) begin
            row_run[c] <= ROW_W'(ROW_W'(left) * ROW_W'(pix[c]));
          end
        end
      end

      if (fin) begin
        if (EW'(fill) < pos_inc) fill <= pos_inc[PW:0];
        if (pos_inc >= effw) begin
          // row end, unfinished run sum dropped
          pos     <= '0;
          cw      <= eff_col;
          row_run <= '0;
        end else begin
          pos <= pos_inc[PW-1:0];
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      idx <= ram_raddr;
      for (int c = 0; c < NCH; c++) begin
        pix[c] <= s_tdata[c*CH_BITS +: CH_BITS];
      end
    end
    if (state == ST_ROWP) begin
      entry_q <= entry_eff;
      for (int c = 0; c < NCH; c++) begin
        prod1[c] <= ROW_W'(ROW_W'(cw) * ROW_W'(pix[c]));
      end
    end
    if (state == ST_HMUL) begin
      for (int c = 0; c < NCH; c++) begin
        prod2[c] <= 31'(22'(row_run[c]) + 22'(prod1[c])) * 31'(cfg.col_recip);
      end
    end
    if (state == ST_CVAL) begin
      for (int c = 0; c < NCH; c++) begin
        // color mode keeps 8 bits per channel between the passes
        cval[c] <= cfg.color_mode ? CVAL_W'(prod2[c][NORM_SHIFT +: CH_BITS])
                                  : prod2[c][NORM_SHIFT +: CVAL_W];
      end
    end
    if (state == ST_COL) begin
      for (int c = 0; c < NCH; c++) begin
        prod3[c] <= SUM_W'(SUM_W'(entry_q.weight) * SUM_W'(cval[c]));
      end
    end
    if (state == ST_VMUL) begin
      for (int c = 0; c < NCH; c++) begin
        prod4[c] <= 37'(28'(entry_q.sum[c]) + 28'(prod3[c])) * 37'(cfg.row_recip);
      end
    end
    if (state == ST_EMIT && out_free) begin
      m_tdata <= {cfg.color_mode ? prod4[2][NORM_SHIFT +: CH_BITS] : 8'h00,
                  cfg.color_mode ? prod4[1][NORM_SHIFT +: CH_BITS] : 8'h00,
                  prod4[0][NORM_SHIFT +: CH_BITS]};
    end
  end

  // memory written only in a step that ends the pixel
  `AAD_ASSERT(a_write_ends_pixel, clk, rst, ram_we |=> state == ST_IDLE, "write not at pixel end")
  // a new output appears only out of the emit step
  `AAD_ASSERT(a_emit_source, clk, rst, $rose(m_tvalid) |-> $past(state) == ST_EMIT, "stray output")
  // an accepted pixel always starts with the memory read step
  `AAD_ASSERT(a_accept_reads, clk, rst, accept |=> state == ST_ROWP, "accept without read step")

endmodule

// ===== sim/area_average_checker.sv =====
// checker for the area average downscaler: predicts output pixels and compares them
`timescale 1ns / 1ps

module area_average_checker import aad_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [23:0]      s_tdata,
  input  logic [0:0]       s_tuser,
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [23:0]      m_tdata,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output int               errors,
  output int               pending
);

  // register copies
  logic                rgb_mode;
  logic [WIDTH_W-1:0]  row_len;
  logic [STEP_W-1:0]   hstep;
  logic [RECIP_W-1:0]  hrecip;
  logic [STEP_W-1:0]   vstep;
  logic [RECIP_W-1:0]  vrecip;

  // accumulation state
  int unsigned       xpos;
  int unsigned       hweight;
  longint unsigned   hsum [3];
  longint unsigned   vsum [MAX_WIDTH][3];
  int unsigned       vweight [MAX_WIDTH];

  logic [23:0] pixels_due [$];

  function automatic int unsigned step_or_unit(logic [STEP_W-1:0] s);
    return (s < 256) ? 256 : int'(s);
  endfunction

  function automatic int unsigned row_len_eff();
    if (row_len == 0) return 1;
    if (row_len > MAX_WIDTH) return MAX_WIDTH;
    return row_len;
  endfunction

  function automatic void restart_row();
    xpos = 0;
    hweight = step_or_unit(hstep);
    for (int c = 0; c < 3; c++) hsum[c] = 0;
  endfunction

  function automatic void restart_frame();
    for (int i = 0; i < MAX_WIDTH; i++) begin
      for (int c = 0; c < 3; c++) vsum[i][c] = 0;
      vweight[i] = step_or_unit(vstep);
    end
    restart_row();
  endfunction

  // fold one source pixel into the sums, queue an output pixel when one completes
  function automatic void fold_pixel(logic fs, logic [23:0] pix_in);
    longint unsigned pix [3];
    longint unsigned cval [3];
    longint unsigned v, cw, rw, rest, vrest;
    int unsigned nch, idx;
    logic [23:0] packed_px;
    if (fs) restart_frame();
    nch = rgb_mode ? 3 : 1;
    for (int c = 0; c < 3; c++) pix[c] = pix_in[8*c +: 8];
    idx = (xpos >= MAX_WIDTH) ? 0 : xpos;
    cw = hweight;
    if (cw > 256) begin
      for (int c = 0; c < nch; c++) hsum[c] += pix[c] << 8;
      cw -= 256;
    end else begin
      rw = vweight[idx];
      for (int c = 0; c < nch; c++) begin
        cval[c] = ((hsum[c] + cw * pix[c]) * longint'(hrecip)) >> 16;
        if (nch == 3) cval[c] &= 64'hff;
      end
      if (rw > 256) begin
        for (int c = 0; c < nch; c++) vsum[idx][c] += cval[c] << 8;
        vweight[idx] = rw - 256;
      end else begin
        packed_px = '0;
        vrest = 256 - rw;
        for (int c = 0; c < nch; c++) begin
          v = ((vsum[idx][c] + rw * cval[c]) * longint'(vrecip)) >> 16;
          packed_px[8*c +: 8] = v[7:0];
          vsum[idx][c] = vrest * cval[c];
        end
        vweight[idx] = step_or_unit(vstep) - vrest;
        pixels_due.push_back(packed_px);
      end
      rest = 256 - cw;
      for (int c = 0; c < nch; c++) hsum[c] = rest * pix[c];
      cw = step_or_unit(hstep) - rest;
    end
    hweight = cw;
    xpos++;
    if (xpos >= row_len_eff()) restart_row();
  endfunction

  always @(posedge clk) begin
    logic [23:0] want;
    if (rst) begin
      rgb_mode = 1'b0;
      row_len  = 12'd2048;
      hstep    = 13'd512;
      hrecip   = 9'd128;
      vstep    = 13'd512;
      vrecip   = 9'd128;
      restart_frame();
      pixels_due.delete();
      errors  <= 0;
    end else begin
      // output side first: a pixel never leaves in the cycle of its own transfer
      if (m_tvalid && m_tready) begin
        if (pixels_due.size() == 0) begin
          $display("%0t: unexpected output pixel, expected none actual %06h", $time, m_tdata);
          errors <= errors + 1;
        end else begin
          want = pixels_due.pop_front();
          if (m_tdata !== want) begin
            $display("%0t: pixel_out expected %06h actual %06h", $time, want, m_tdata);
            errors <= errors + 1;
          end
        end
      end
      if (s_tvalid && s_tready) fold_pixel(s_tuser[0], s_tdata);
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_COLOR_MODE: rgb_mode = cfg_data[0];
          REG_SRC_WIDTH:  row_len  = cfg_data[WIDTH_W-1:0];
          REG_COL_STEP:   hstep    = cfg_data[STEP_W-1:0];
          REG_COL_RECIP:  hrecip   = cfg_data[RECIP_W-1:0];
          REG_ROW_STEP:   vstep    = cfg_data[STEP_W-1:0];
          REG_ROW_RECIP:  vrecip   = cfg_data[RECIP_W-1:0];
          default: ;
        endcase
      end
    end
    pending <= pixels_due.size();
  end

endmodule

// ===== sim/tb_area_average_image_downscaler.sv =====
// testbench top: stimulus, idling patterns and verdict for the area average downscaler
`timescale 1ns / 1ps

module tb_area_average_image_downscaler;
  import aad_pkg::*;

  localparam int LIMIT_CYCLES = 3000000;
  localparam int RANDOM_ITEMS = 1550;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [23:0]      s_tdata;   // pixel_in [23:0]
  logic [0:0]       s_tuser;   // frame_start [0]
  logic             m_tvalid;
  logic             m_tready;
  logic [23:0]      m_tdata;   // pixel_out [23:0]
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  int errors;
  int pending;
  int cycles = 0;

  // idling odds in percent, changed per phase
  int src_idle_pct;
  int sink_stall_pct;

  area_average_image_downscaler DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  area_average_checker CHK (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog on total run length
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("area_average_image_downscaler: mismatch");
      $finish;
    end
  end

  // receiver side stalls at random
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // one pixel transfer; called and returning at a falling edge
  task automatic push_pixel(input logic fs, input logic [23:0] pix);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    s_tuser  <= fs;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // drain: all due pixels out, then the block's worst case latency for pixels
  // that close no output
  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  // all six registers in back to back writes, enable lowered once at the end
  task automatic program_regs(input logic rgb, input int unsigned w, input int unsigned cs,
                              input int unsigned cr, input int unsigned rs,
                              input int unsigned rr);
    cfg_we <= 1'b1;
    cfg_index <= REG_COLOR_MODE; cfg_data <= CFG_W'(rgb); @(negedge clk);
    cfg_index <= REG_SRC_WIDTH;  cfg_data <= CFG_W'(w);   @(negedge clk);
    cfg_index <= REG_COL_STEP;   cfg_data <= CFG_W'(cs);  @(negedge clk);
    cfg_index <= REG_COL_RECIP;  cfg_data <= CFG_W'(cr);  @(negedge clk);
    cfg_index <= REG_ROW_STEP;   cfg_data <= CFG_W'(rs);  @(negedge clk);
    cfg_index <= REG_ROW_RECIP;  cfg_data <= CFG_W'(rr);  @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic int unsigned recip_of(int unsigned s);
    int unsigned r;
    r = (s < 256) ? 256 : 65536 / s;
    return (r < 16) ? 16 : r;
  endfunction

  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned w, weff, rows, frames, cs, cr, rs, rr;
    int unsigned per_frame;
    logic rgb;
    logic [23:0] edge_px [8];
    edge_px = '{24'h000000, 24'hffffff, 24'hff0000, 24'h00ff00,
                24'h0000ff, 24'h123456, 24'ha5a5a5, 24'h5a5a5a};
    src_idle_pct = 0;
    sink_stall_pct = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = REG_COLOR_MODE;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: unit steps pass every pixel through, so channel extremes show directly
    program_regs(1'b1, 4, 256, 256, 256, 256);
    foreach (edge_px[i]) push_pixel(i == 0, edge_px[i]);
    drain();
    program_regs(1'b0, 4, 256, 256, 256, 256);
    foreach (edge_px[i]) push_pixel(i == 0, edge_px[i]);
    // two more pixels at the same unit steps, the first one opening a new frame
    push_pixel(1'b1, 24'hffffff);
    push_pixel(1'b0, 24'h0000ff);
    drain();

    // random phases
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 51; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 51; end
        default: begin src_idle_pct = 23; sink_stall_pct = 23; end
      endcase
      rgb = 1'($urandom_range(0, 1));
      rows = $urandom_range(1, 6);
      frames = $urandom_range(1, 3);
      case (phase)
        // widest column step, smallest reciprocal
        0: begin w = 32; cs = 4096; cr = 16; rs = 256; rr = 256; end
        // width above the limit saturates, one long partial row
        1: begin w = 4095; cs = 256; cr = 256; rs = 256; rr = 256; rows = 1; frames = 1; end
        // zero width acts as one, steps below one pixel
        2: begin w = 0; cs = 0; cr = 256; rs = 255; rr = 256; rows = 8; end
        // tallest row step
        3: begin w = 2; cs = 256; cr = 256; rs = 4096; rr = 16; rows = 20; frames = 1; end
        default: begin
          w  = $urandom_range(1, 12);
          cs = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(256, 900);
          rs = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(256, 900);
          // reciprocals mostly consistent, sometimes arbitrary
          cr = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 256) : recip_of(cs);
          rr = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 256) : recip_of(rs);
        end
      endcase
      program_regs(rgb, w, cs, cr, rs, rr);
      weff = (w == 0) ? 1 : (w > 2048) ? 2048 : w;
      per_frame = rows * weff;
      // long row kept partial so the item count stays near its target
      if (phase == 1) per_frame = 1200;
      for (int f = 0; f < frames; f++) begin
        for (int n = 0; n < per_frame; n++) begin
          logic fs;
          // first phase frame sometimes continues the old one (mode or width change
          // mid frame); rare stray frame marks inside a frame
          fs = (n == 0) ? (f != 0 || $urandom_range(0, 3) != 0)
                        : ($urandom_range(0, 99) == 0);
          push_pixel(fs, 24'($urandom()));
          sent++;
        end
      end
      drain();
      phase++;
    end

    @(negedge clk);
    if (errors == 0) begin
      $display("area_average_image_downscaler: match");
    end else begin
      $display("area_average_image_downscaler: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/aad_pkg.sv
hw/rtl/aad_ram.sv
hw/rtl/aad_cfg.sv
hw/rtl/area_average_image_downscaler.sv
sim/area_average_checker.sv
sim/tb_area_average_image_downscaler.sv
